FILE: rtl/core/si_pkg.sv
// shared codes for the segment intersection core
`default_nettype none
package si_pkg;
    localparam logic [1:0] HIT_FOUND    = 2'd0;
    localparam logic [1:0] HIT_PARALLEL = 2'd1;
    localparam logic [1:0] HIT_OUTSIDE  = 2'd2;
endpackage
`default_nettype wire

FILE: rtl/core/si_front.sv
// front pipeline: line coefficients, determinant, cramer numerators and their magnitudes
`default_nettype none
module si_front #(
    parameter int W = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [W-1:0]      ax0,
    input  wire logic [W-1:0]      ay0,
    input  wire logic [W-1:0]      ax1,
    input  wire logic [W-1:0]      ay1,
    input  wire logic [W-1:0]      bx0,
    input  wire logic [W-1:0]      by0,
    input  wire logic [W-1:0]      bx1,
    input  wire logic [W-1:0]      by1,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [3*W+3:0]         mag_x,
    output logic [3*W+3:0]         mag_y,
    output logic [2*W+2:0]         det_mag,
    output logic                   neg_x,
    output logic                   neg_y,
    output logic                   det_zero,
    output logic [8*W-1:0]         bounds
);
    localparam int P_W = 2*W + 1;
    localparam int C_W = 2*W + 2;
    localparam int D_W = 2*W + 3;
    localparam int M_W = 3*W + 3;
    localparam int N_W = 3*W + 4;

    logic [4:0] v_reg, v_next;
    logic [5:0] rdy;

    // stage 1
    logic signed [W:0]   aa_reg, ab_reg, ba_reg, bb_reg;
    logic signed [W:0]   aa_next, ab_next, ba_next, bb_next;
    logic signed [W-1:0] ax0_reg, ay0_reg, bx0_reg, by0_reg;
    logic [8*W-1:0]      bnd1_reg, bnd1_next;
    // stage 2
    logic signed [P_W-1:0] pax_reg, pay_reg, pbx_reg, pby_reg;
    logic signed [P_W-1:0] pax_next, pay_next, pbx_next, pby_next;
    logic signed [C_W-1:0] pd1_reg, pd2_reg, pd1_next, pd2_next;
    logic signed [W:0]     aa2_reg, ab2_reg, ba2_reg, bb2_reg;
    logic [8*W-1:0]        bnd2_reg;
    // stage 3
    logic signed [C_W-1:0] ca_reg, cb_reg, ca_next, cb_next;
    logic signed [D_W-1:0] det3_reg, det3_next;
    logic signed [W:0]     aa3_reg, ab3_reg, ba3_reg, bb3_reg;
    logic [8*W-1:0]        bnd3_reg;
    // stage 4
    logic signed [M_W-1:0] nx1_reg, nx2_reg, ny1_reg, ny2_reg;
    logic signed [M_W-1:0] nx1_next, nx2_next, ny1_next, ny2_next;
    logic signed [D_W-1:0] det4_reg;
    logic [8*W-1:0]        bnd4_reg;
    // stage 5
    logic signed [N_W-1:0] numx, numy;
    logic [N_W-1:0]        magx_reg, magy_reg, magx_next, magy_next;
    logic [D_W-1:0]        dmag_reg, dmag_next;
    logic                  negx_reg, negy_reg, zero_reg;
    logic                  negx_next, negy_next, zero_next;
    logic [8*W-1:0]        bnd5_reg;

    // a stage takes a word when it is empty or its word moves on
    always_comb begin
        rdy[5] = out_ready;
        for (int k = 4; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        v_next[0] = rdy[0] ? in_valid : v_reg[0];
        for (int k = 1; k < 5; k++) begin
            v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_comb begin
        aa_next = $signed({ay1[W-1], ay1}) - $signed({ay0[W-1], ay0});
        ab_next = $signed({ax0[W-1], ax0}) - $signed({ax1[W-1], ax1});
        ba_next = $signed({by1[W-1], by1}) - $signed({by0[W-1], by0});
        bb_next = $signed({bx0[W-1], bx0}) - $signed({bx1[W-1], bx1});
        bnd1_next[0*W +: W] = ($signed(ax0) < $signed(ax1)) ? ax0 : ax1;
        bnd1_next[1*W +: W] = ($signed(ax0) < $signed(ax1)) ? ax1 : ax0;
        bnd1_next[2*W +: W] = ($signed(ay0) < $signed(ay1)) ? ay0 : ay1;
        bnd1_next[3*W +: W] = ($signed(ay0) < $signed(ay1)) ? ay1 : ay0;
        bnd1_next[4*W +: W] = ($signed(bx0) < $signed(bx1)) ? bx0 : bx1;
        bnd1_next[5*W +: W] = ($signed(bx0) < $signed(bx1)) ? bx1 : bx0;
        bnd1_next[6*W +: W] = ($signed(by0) < $signed(by1)) ? by0 : by1;
        bnd1_next[7*W +: W] = ($signed(by0) < $signed(by1)) ? by1 : by0;

        pax_next = P_W'(aa_reg) * P_W'(ax0_reg);
        pay_next = P_W'(ab_reg) * P_W'(ay0_reg);
        pbx_next = P_W'(ba_reg) * P_W'(bx0_reg);
        pby_next = P_W'(bb_reg) * P_W'(by0_reg);
        pd1_next = C_W'(aa_reg) * C_W'(bb_reg);
        pd2_next = C_W'(ba_reg) * C_W'(ab_reg);

        ca_next   = C_W'(pax_reg) + C_W'(pay_reg);
        cb_next   = C_W'(pbx_reg) + C_W'(pby_reg);
        det3_next = D_W'(pd1_reg) - D_W'(pd2_reg);

        nx1_next = M_W'(bb3_reg) * M_W'(ca_reg);
        nx2_next = M_W'(ab3_reg) * M_W'(cb_reg);
        ny1_next = M_W'(aa3_reg) * M_W'(cb_reg);
        ny2_next = M_W'(ba3_reg) * M_W'(ca_reg);

        numx      = N_W'(nx1_reg) - N_W'(nx2_reg);
        numy      = N_W'(ny1_reg) - N_W'(ny2_reg);
        magx_next = numx[N_W-1] ? N_W'(-numx) : N_W'(numx);
        magy_next = numy[N_W-1] ? N_W'(-numy) : N_W'(numy);
        dmag_next = det4_reg[D_W-1] ? D_W'(-det4_reg) : D_W'(det4_reg);
        negx_next = numx[N_W-1] ^ det4_reg[D_W-1];
        negy_next = numy[N_W-1] ^ det4_reg[D_W-1];
        zero_next = (det4_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            aa_reg <= aa_next; ab_reg <= ab_next; ba_reg <= ba_next; bb_reg <= bb_next;
            ax0_reg <= ax0; ay0_reg <= ay0; bx0_reg <= bx0; by0_reg <= by0;
            bnd1_reg <= bnd1_next;
        end
        if (rdy[1]) begin
            pax_reg <= pax_next; pay_reg <= pay_next;
            pbx_reg <= pbx_next; pby_reg <= pby_next;
            pd1_reg <= pd1_next; pd2_reg <= pd2_next;
            aa2_reg <= aa_reg; ab2_reg <= ab_reg; ba2_reg <= ba_reg; bb2_reg <= bb_reg;
            bnd2_reg <= bnd1_reg;
        end
        if (rdy[2]) begin
            ca_reg <= ca_next; cb_reg <= cb_next; det3_reg <= det3_next;
            aa3_reg <= aa2_reg; ab3_reg <= ab2_reg; ba3_reg <= ba2_reg; bb3_reg <= bb2_reg;
            bnd3_reg <= bnd2_reg;
        end
        if (rdy[3]) begin
            nx1_reg <= nx1_next; nx2_reg <= nx2_next;
            ny1_reg <= ny1_next; ny2_reg <= ny2_next;
            det4_reg <= det3_reg;
            bnd4_reg <= bnd3_reg;
        end
        if (rdy[4]) begin
            magx_reg <= magx_next; magy_reg <= magy_next; dmag_reg <= dmag_next;
            negx_reg <= negx_next; negy_reg <= negy_next; zero_reg <= zero_next;
            bnd5_reg <= bnd4_reg;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[4];
    assign mag_x     = magx_reg;
    assign mag_y     = magy_reg;
    assign det_mag   = dmag_reg;
    assign neg_x     = negx_reg;
    assign neg_y     = negy_reg;
    assign det_zero  = zero_reg;
    assign bounds    = bnd5_reg;
endmodule
`default_nettype wire

FILE: rtl/core/si_div_cell.sv
// one restoring division step for both quotient lanes, with its own pipeline register
`default_nettype none
module si_div_cell #(
    parameter int N_W    = 52,
    parameter int D_W    = 35,
    parameter int SIDE_W = 131
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [D_W-1:0]    in_rem_x,
    input  wire logic [N_W-1:0]    in_nq_x,
    input  wire logic [D_W-1:0]    in_rem_y,
    input  wire logic [N_W-1:0]    in_nq_y,
    input  wire logic [D_W-1:0]    in_div,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [D_W-1:0]         out_rem_x,
    output logic [N_W-1:0]         out_nq_x,
    output logic [D_W-1:0]         out_rem_y,
    output logic [N_W-1:0]         out_nq_y,
    output logic [D_W-1:0]         out_div,
    output logic [SIDE_W-1:0]      out_side
);
    logic              valid_reg, valid_next;
    logic [D_W-1:0]    remx_reg, remx_next, remy_reg, remy_next, div_reg;
    logic [N_W-1:0]    nqx_reg, nqx_next, nqy_reg, nqy_next;
    logic [SIDE_W-1:0] side_reg;
    logic [D_W:0]      shx, shy, dfx, dfy;
    logic              gex, gey;

    // numerator bits leave at the top, quotient bits enter at the bottom
    always_comb begin
        shx = {in_rem_x, in_nq_x[N_W-1]};
        shy = {in_rem_y, in_nq_y[N_W-1]};
        dfx = shx - {1'b0, in_div};
        dfy = shy - {1'b0, in_div};
        gex = !dfx[D_W];
        gey = !dfy[D_W];
        remx_next = gex ? dfx[D_W-1:0] : shx[D_W-1:0];
        remy_next = gey ? dfy[D_W-1:0] : shy[D_W-1:0];
        nqx_next  = {in_nq_x[N_W-2:0], gex};
        nqy_next  = {in_nq_y[N_W-2:0], gey};
        valid_next = in_ready ? in_valid : valid_reg;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            remx_reg <= remx_next;
            remy_reg <= remy_next;
            nqx_reg  <= nqx_next;
            nqy_reg  <= nqy_next;
            div_reg  <= in_div;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem_x = remx_reg;
    assign out_nq_x  = nqx_reg;
    assign out_rem_y = remy_reg;
    assign out_nq_y  = nqy_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;
endmodule
`default_nettype wire

FILE: rtl/core/si_back.sv
// quotient sign, bounding box tests and output register
`default_nettype none
module si_back #(
    parameter int W = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [3*W+3:0] q_x,
    input  wire logic [3*W+3:0] q_y,
    input  wire logic          neg_x,
    input  wire logic          neg_y,
    input  wire logic          det_zero,
    input  wire logic [8*W-1:0] bounds,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [1:0]         hit_status,
    output logic [W-1:0]       cross_x,
    output logic [W-1:0]       cross_y
);
    import si_pkg::*;

    localparam int S_W = 3*W + 5;

    logic              valid_reg, valid_next;
    logic [1:0]        hit_reg, hit_next;
    logic [W-1:0]      cx_reg, cx_next, cy_reg, cy_next;
    logic signed [S_W-1:0] sx, sy;
    logic signed [S_W-1:0] lo_ax, hi_ax, lo_ay, hi_ay, lo_bx, hi_bx, lo_by, hi_by;
    logic              in_box;

    always_comb begin
        sx = neg_x ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
        sy = neg_y ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
        lo_ax = S_W'($signed(bounds[0*W +: W]));
        hi_ax = S_W'($signed(bounds[1*W +: W]));
        lo_ay = S_W'($signed(bounds[2*W +: W]));
        hi_ay = S_W'($signed(bounds[3*W +: W]));
        lo_bx = S_W'($signed(bounds[4*W +: W]));
        hi_bx = S_W'($signed(bounds[5*W +: W]));
        lo_by = S_W'($signed(bounds[6*W +: W]));
        hi_by = S_W'($signed(bounds[7*W +: W]));
        in_box = (sx >= lo_ax) && (sx <= hi_ax) && (sy >= lo_ay) && (sy <= hi_ay) &&
                 (sx >= lo_bx) && (sx <= hi_bx) && (sy >= lo_by) && (sy <= hi_by);
        hit_next = HIT_OUTSIDE;
        cx_next  = '0;
        cy_next  = '0;
        if (det_zero) begin
            hit_next = HIT_PARALLEL;
        end else if (in_box) begin
            hit_next = HIT_FOUND;
            cx_next  = sx[W-1:0];
            cy_next  = sy[W-1:0];
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            hit_reg <= hit_next;
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
        end
    end

    assign out_valid  = valid_reg;
    assign hit_status = hit_reg;
    assign cross_x    = cx_reg;
    assign cross_y    = cy_reg;
endmodule
`default_nettype wire

FILE: rtl/core/segment_intersection_core.sv
// from input word to result word, each word passes through these registers:
// five front stages, one divider cell per quotient bit, one output register.
// throughput: one word per cycle unless the result stalls; each stage holds one word
// and fills empty slots, so a stalled result backs up the pipe one stage at a time.
// reset: synchronous active-low aresetn clears every stage's valid flag.
`default_nettype none
module segment_intersection_core #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
    // seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y
    input  wire logic [((8*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // hit_status, cross_x, cross_y, zero pad
    output logic [((2*COORD_WIDTH+2+7)/8)*8-1:0] m_tdata
);
    import si_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int N_W    = 3*W + 4;
    localparam int D_W    = 2*W + 3;
    localparam int SIDE_W = 8*W + 3;
    localparam int OUT_W  = ((2*W+2+7)/8)*8;

    logic              f_valid, f_ready, f_negx, f_negy, f_zero;
    logic [N_W-1:0]    f_magx, f_magy;
    logic [D_W-1:0]    f_dmag;
    logic [8*W-1:0]    f_bnd;

    logic              c_valid [0:N_W];
    logic              c_ready [0:N_W];
    logic [D_W-1:0]    c_remx  [0:N_W];
    logic [D_W-1:0]    c_remy  [0:N_W];
    logic [N_W-1:0]    c_nqx   [0:N_W];
    logic [N_W-1:0]    c_nqy   [0:N_W];
    logic [D_W-1:0]    c_div   [0:N_W];
    logic [SIDE_W-1:0] c_side  [0:N_W];

    logic [1:0]        hit;
    logic [W-1:0]      cx, cy;

    si_front #(.W(W)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .ax0(s_tdata[0*W +: W]), .ay0(s_tdata[1*W +: W]),
        .ax1(s_tdata[2*W +: W]), .ay1(s_tdata[3*W +: W]),
        .bx0(s_tdata[4*W +: W]), .by0(s_tdata[5*W +: W]),
        .bx1(s_tdata[6*W +: W]), .by1(s_tdata[7*W +: W]),
        .out_valid(f_valid), .out_ready(f_ready),
        .mag_x(f_magx), .mag_y(f_magy), .det_mag(f_dmag),
        .neg_x(f_negx), .neg_y(f_negy), .det_zero(f_zero), .bounds(f_bnd)
    );

    assign c_valid[0] = f_valid;
    assign f_ready    = c_ready[0];
    assign c_remx[0]  = '0;
    assign c_remy[0]  = '0;
    assign c_nqx[0]   = f_magx;
    assign c_nqy[0]   = f_magy;
    assign c_div[0]   = f_dmag;
    assign c_side[0]  = {f_negx, f_negy, f_zero, f_bnd};

    for (genvar i = 0; i < N_W; i++) begin : g_cell
        si_div_cell #(.N_W(N_W), .D_W(D_W), .SIDE_W(SIDE_W)) u_cell (
            .aclk(aclk), .aresetn(aresetn),
            .in_valid(c_valid[i]), .in_ready(c_ready[i]),
            .in_rem_x(c_remx[i]), .in_nq_x(c_nqx[i]),
            .in_rem_y(c_remy[i]), .in_nq_y(c_nqy[i]),
            .in_div(c_div[i]), .in_side(c_side[i]),
            .out_valid(c_valid[i+1]), .out_ready(c_ready[i+1]),
            .out_rem_x(c_remx[i+1]), .out_nq_x(c_nqx[i+1]),
            .out_rem_y(c_remy[i+1]), .out_nq_y(c_nqy[i+1]),
            .out_div(c_div[i+1]), .out_side(c_side[i+1])
        );
    end

    si_back #(.W(W)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(c_valid[N_W]), .in_ready(c_ready[N_W]),
        .q_x(c_nqx[N_W]), .q_y(c_nqy[N_W]),
        .neg_x(c_side[N_W][SIDE_W-1]), .neg_y(c_side[N_W][SIDE_W-2]),
        .det_zero(c_side[N_W][SIDE_W-3]), .bounds(c_side[N_W][8*W-1:0]),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .hit_status(hit), .cross_x(cx), .cross_y(cy)
    );

    assign m_tdata = OUT_W'({cy, cx, hit});

    // a miss carries zero coordinates
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && hit != HIT_FOUND |-> cx == '0 && cy == '0)
        else $error("nonzero coordinates on a miss");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> hit == HIT_FOUND || hit == HIT_PARALLEL || hit == HIT_OUTSIDE)
        else $error("unknown hit status");

    // input back pressure only comes from a stalled full pipe
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output stall");

    assert property (@(posedge aclk) $past(!aresetn) |-> !m_tvalid)
        else $error("result word right after reset");
endmodule
`default_nettype wire
